// ----- src/fuzzy_subsequence_scorer_assert.svh -----
// assertion macros for the fuzzy subsequence scorer
// used by the top level, which supplies aclk and aresetn in scope
`ifndef FUZZY_SUBSEQUENCE_SCORER_ASSERT_SVH
`define FUZZY_SUBSEQUENCE_SCORER_ASSERT_SVH

// same-cycle implication, off while reset is held
`define FSS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define FSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fss_pkg.sv -----
// shared types, constants and helper functions for the fuzzy subsequence scorer
// no dependencies; imported by fss_ctrl, fss_datapath, the top level and the testbench
package fss_pkg;

    // field widths
    localparam int PATTERN_MAX     = 32;
    localparam int SLOT_W          = 5;
    localparam int PLEN_W          = 6;
    localparam int CHAR_W          = 16;
    localparam int TEXT_MAX        = 4096;
    localparam int POS_W           = $clog2(TEXT_MAX);
    localparam int SCORE_FRAC_BITS = 16;
    localparam int SCORE_W         = 28;
    localparam int BONUS_W         = 8;
    localparam int GAP_W           = 12;
    localparam int DIV_CNT_W       = $clog2(SCORE_FRAC_BITS);
    localparam int DEN_W           = POS_W + 1;
    localparam int CFG_DATA_W      = PLEN_W;
    localparam int S_TDATA_W       = ((SLOT_W + CHAR_W + 7) / 8) * 8;
    localparam int M_PAYLOAD_W     = POS_W + 2 + SCORE_W;
    localparam int M_TDATA_W       = ((M_PAYLOAD_W + 7) / 8) * 8;

    typedef logic [CHAR_W-1:0] char_t;

    // opcodes carried on s_tuser
    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_TEXT      = 2'd1;
    localparam logic [1:0] OP_EMPTY_END = 2'd2;

    // configuration register indexes
    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_CASE_SENSITIVE = 1'b1;

    // word separators
    localparam char_t CH_SPACE      = 16'h0020;
    localparam char_t CH_SLASH      = 16'h002F;
    localparam char_t CH_BACKSLASH  = 16'h005C;
    localparam char_t CH_DASH       = 16'h002D;
    localparam char_t CH_UNDERSCORE = 16'h005F;
    localparam char_t CH_UPPER_A    = 16'h0041;
    localparam char_t CH_UPPER_Z    = 16'h005A;
    localparam char_t CASE_OFFSET   = 16'h0020;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_MAX - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SCORE_FRAC_BITS - 1);
    localparam logic signed [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << SCORE_FRAC_BITS;

    typedef enum logic {
        FSS_RUN,
        FSS_DIV
    } fss_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
        logic div_done;
    } fss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_result;
        logic need_div;
        logic div_last;
    } fss_status_t;

    function automatic char_t fold_char(input char_t c, input logic case_sensitive);
        if (!case_sensitive && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic is_separator(input char_t c);
        return (c == CH_SPACE) || (c == CH_SLASH) || (c == CH_BACKSLASH)
            || (c == CH_DASH) || (c == CH_UNDERSCORE);
    endfunction

endpackage

// ----- src/fuzzy_subsequence_scorer.sv -----
// top level of the fuzzy subsequence scorer: ports, field packing, assertions
// depends on fss_pkg, fss_ctrl, fss_datapath and fuzzy_subsequence_scorer_assert.svh
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   opcode, pattern_slot, char_code, last_char
//  m_        out        m_tvalid/m_tready   text_position, hit, done_res, matched, score
//  cfg_      in         cfg_we              pattern_length, case_sensitive
//
// a load, a text character or an end marker is taken at one item per cycle unless a divide or a held result stalls it
// a final character that completes a non-empty pattern starts a divide: the
// length term L/(L+1) comes from a restoring divider giving one quotient bit a cycle
// a result waiting in the output register with m_tready low holds off s_tready
// reset clears the control and string state; the pattern store is undefined until loaded
`include "fuzzy_subsequence_scorer_assert.svh"

module fuzzy_subsequence_scorer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [4:0] pattern_slot, [20:5] char_code, rest zero
    input  logic [fss_pkg::S_TDATA_W-1:0]        s_tdata,
    // [1:0] opcode
    input  logic [1:0]                           s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [11:0] text_position, [12] hit, [13] matched, [41:14] score, rest zero
    output logic [fss_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import fss_pkg::*;

    fss_cmd_t    cmd;
    fss_status_t status;

    logic [POS_W-1:0]          text_position;
    logic                      hit;
    logic                      done_res;
    logic                      matched;
    logic signed [SCORE_W-1:0] score;

    fss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fss_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .opcode        (s_tuser),
        .pattern_slot  (s_tdata[SLOT_W-1:0]),
        .char_code     (s_tdata[SLOT_W+CHAR_W-1:SLOT_W]),
        .last_char     (s_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .text_position (text_position),
        .hit           (hit),
        .done_res      (done_res),
        .matched       (matched),
        .score         (score)
    );

    // result packing
    assign m_tdata = {{(M_TDATA_W-M_PAYLOAD_W){1'b0}}, score, matched, hit, text_position};
    assign m_tlast = done_res;

    // checks
    `FSS_ASSERT_NEXT(a_div_blocks_input, cmd.take && status.need_div, !s_tready, "input taken during divide")
    `FSS_ASSERT_NEXT(a_div_done_result, cmd.div_done, m_tvalid && m_tlast && matched, "divide end gave no final result")
    `FSS_ASSERT_NOW(a_partial_no_score, m_tvalid && !m_tlast, !matched && score == '0, "partial item carries a score")

endmodule

// ----- src/fss_ctrl.sv -----
// controller for the fuzzy subsequence scorer: handshake, divide sequencing,
// result valid flag; depends on fss_pkg
module fss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  fss_pkg::fss_status_t status,
    output fss_pkg::fss_cmd_t    cmd
);
    import fss_pkg::*;

    fss_state_t state_reg;
    fss_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_load;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSS_RUN: begin
                if (cmd.take && status.need_div) begin
                    state_next = FSS_DIV;
                end
            end
            FSS_DIV: begin
                if (status.div_last) begin
                    state_next = FSS_DIV == state_reg ? FSS_RUN : state_reg;
                end
            end
            default: state_next = FSS_RUN;
        endcase
    end

    // outputs and commands
    always_comb begin
        s_tready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.div_done = 1'b0;
        unique case (state_reg)
            FSS_RUN: begin
                s_tready = !out_valid_reg || m_tready;
                cmd.take = s_tvalid && s_tready;
            end
            FSS_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_done = status.div_last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result register valid flag
    assign out_load = (cmd.take && status.has_result && !status.need_div) || cmd.div_done;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSS_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- src/fss_datapath.sv -----
// datapath for the fuzzy subsequence scorer: pattern store, per-string state,
// match and bonus logic, serial divider, result payload; depends on fss_pkg
module fss_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fss_pkg::fss_cmd_t                    cmd,
    output fss_pkg::fss_status_t                 status,
    input  logic [1:0]                           opcode,
    input  logic [fss_pkg::SLOT_W-1:0]           pattern_slot,
    input  fss_pkg::char_t                       char_code,
    input  logic                                 last_char,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic [fss_pkg::POS_W-1:0]            text_position,
    output logic                                 hit,
    output logic                                 done_res,
    output logic                                 matched,
    output logic signed [fss_pkg::SCORE_W-1:0]   score
);
    import fss_pkg::*;

    // configuration
    logic [PLEN_W-1:0] plen_reg;
    logic              case_reg;

    // pattern store, no reset
    char_t pattern_store [PATTERN_MAX];
    char_t             pat_char_reg;
    logic [SLOT_W-1:0] fetch_slot;

    // per-string state
    logic [PLEN_W-1:0]  pat_pos_reg,   pat_pos_next;
    logic [POS_W-1:0]   text_pos_reg,  text_pos_next;
    logic               prev_hit_reg,  prev_hit_next;
    logic [POS_W-1:0]   last_hit_reg,  last_hit_next;
    logic               any_hit_reg,   any_hit_next;
    char_t              prev_char_reg, prev_char_next;
    logic [BONUS_W-1:0] bonus_reg,     bonus_next;
    logic [GAP_W-1:0]   gap_reg,       gap_next;

    // divider
    logic [DEN_W-1:0]           rem_reg, rem_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [SCORE_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DEN_W:0]             rem_dbl;
    logic                       rem_ge;

    // result payload
    logic [POS_W-1:0]          pos_out_reg;
    logic                      hit_out_reg;
    logic                      done_out_reg;
    logic                      matched_out_reg;
    logic signed [SCORE_W-1:0] score_out_reg;

    // match logic
    logic [PLEN_W-1:0]  act_len;
    logic               empty_pat;
    logic               is_text;
    logic               is_end;
    logic               is_done;
    logic               hit_now;
    logic               word_start;
    logic [2:0]         bonus_add;
    logic [BONUS_W:0]   bonus_wide;
    logic [BONUS_W-1:0] bonus_new;
    logic [GAP_W-1:0]   gap_delta;
    logic [GAP_W:0]     gap_wide;
    logic [GAP_W-1:0]   gap_new;
    logic [PLEN_W-1:0]  pat_pos_new;
    logic               ok_now;
    logic [BONUS_W-1:0] bonus_use;
    logic [GAP_W-1:0]   gap_use;
    logic signed [SCORE_W-1:0] score_part;
    logic signed [SCORE_W-1:0] score_now;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
            case_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: plen_reg <= cfg_wdata[PLEN_W-1:0];
                REG_CASE_SENSITIVE: case_reg <= cfg_wdata[0];
                default:            plen_reg <= plen_reg;
            endcase
        end
    end

    // pattern store writes
    always_ff @(posedge aclk) begin
        if (cmd.take && opcode == OP_LOAD) begin
            pattern_store[pattern_slot] <= char_code;
        end
    end

    // fetch the character at the next match position, a load to that slot goes straight through
    assign fetch_slot = aresetn ? pat_pos_next[SLOT_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.take && opcode == OP_LOAD && pattern_slot == fetch_slot) begin
            pat_char_reg <= char_code;
        end else begin
            pat_char_reg <= pattern_store[fetch_slot];
        end
    end

    // compare against the next pattern character
    assign act_len   = (plen_reg > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : plen_reg;
    assign empty_pat = (act_len == '0);
    assign is_text   = (opcode == OP_TEXT);
    assign is_end    = (opcode == OP_EMPTY_END);
    assign is_done   = is_end || (is_text && last_char);
    assign hit_now   = is_text && (pat_pos_reg < act_len)
                     && (fold_char(pat_char_reg, case_reg) == fold_char(char_code, case_reg));

    // bonus for this hit, saturating
    assign word_start = (text_pos_reg == '0) || is_separator(prev_char_reg);
    assign bonus_add  = 3'd1 + (prev_hit_reg ? 3'd2 : 3'd0) + (word_start ? 3'd1 : 3'd0);
    assign bonus_wide = {1'b0, bonus_reg} + (BONUS_W+1)'(bonus_add);
    assign bonus_new  = bonus_wide[BONUS_W] ? '1 : bonus_wide[BONUS_W-1:0];

    // gap since the previous hit, saturating
    assign gap_delta = text_pos_reg - last_hit_reg - POS_W'(1);
    assign gap_wide  = {1'b0, gap_reg} + {1'b0, gap_delta};
    assign gap_new   = (!prev_hit_reg && any_hit_reg && text_pos_reg > last_hit_reg)
                     ? (gap_wide[GAP_W] ? '1 : gap_wide[GAP_W-1:0]) : gap_reg;

    assign pat_pos_new = pat_pos_reg + PLEN_W'(hit_now);
    assign ok_now      = is_text ? (pat_pos_new >= act_len) : empty_pat;

    // score without the length term
    assign bonus_use  = hit_now ? bonus_new : bonus_reg;
    assign gap_use    = hit_now ? gap_new : gap_reg;
    assign score_part = $signed({{(SCORE_W-BONUS_W-SCORE_FRAC_BITS){1'b0}}, bonus_use,
                                 {SCORE_FRAC_BITS{1'b0}}})
                      - $signed({{(SCORE_W-GAP_W-SCORE_FRAC_BITS+1){1'b0}}, gap_use,
                                 {(SCORE_FRAC_BITS-1){1'b0}}});
    assign score_now  = (is_done && ok_now && empty_pat) ? SCORE_ONE : '0;

    // status to the controller
    assign status.has_result = is_text || is_end;
    assign status.need_div   = is_text && last_char && ok_now && !empty_pat;
    assign status.div_last   = (cnt_reg == DIV_LAST);

    // per-string state update
    always_comb begin
        pat_pos_next   = pat_pos_reg;
        text_pos_next  = text_pos_reg;
        prev_hit_next  = prev_hit_reg;
        last_hit_next  = last_hit_reg;
        any_hit_next   = any_hit_reg;
        prev_char_next = prev_char_reg;
        bonus_next     = bonus_reg;
        gap_next       = gap_reg;
        if (cmd.take) begin
            priority if (is_done) begin
                pat_pos_next   = '0;
                text_pos_next  = '0;
                prev_hit_next  = 1'b0;
                last_hit_next  = '0;
                any_hit_next   = 1'b0;
                prev_char_next = '0;
                bonus_next     = '0;
                gap_next       = '0;
            end else if (is_text) begin
                if (hit_now) begin
                    pat_pos_next  = pat_pos_new;
                    last_hit_next = text_pos_reg;
                    any_hit_next  = 1'b1;
                    bonus_next    = bonus_new;
                    gap_next      = gap_new;
                end
                prev_hit_next  = hit_now;
                prev_char_next = char_code;
                if (text_pos_reg != POS_LAST) begin
                    text_pos_next = text_pos_reg + POS_W'(1);
                end
            end else begin
                // loads and ignored opcodes leave the string as it is
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_pos_reg   <= '0;
            text_pos_reg  <= '0;
            prev_hit_reg  <= 1'b0;
            last_hit_reg  <= '0;
            any_hit_reg   <= 1'b0;
            prev_char_reg <= '0;
            bonus_reg     <= '0;
            gap_reg       <= '0;
        end else begin
            pat_pos_reg   <= pat_pos_next;
            text_pos_reg  <= text_pos_next;
            prev_hit_reg  <= prev_hit_next;
            last_hit_reg  <= last_hit_next;
            any_hit_reg   <= any_hit_next;
            prev_char_reg <= prev_char_next;
            bonus_reg     <= bonus_next;
            gap_reg       <= gap_next;
        end
    end

    // restoring divider for L/(L+1), one quotient bit per cycle
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, den_reg});

    always_comb begin
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        priority if (cmd.take && status.need_div) begin
            rem_next = {1'b0, text_pos_reg} + DEN_W'(1);
            den_next = {1'b0, text_pos_reg} + DEN_W'(2);
            quo_next = '0;
            cnt_next = '0;
        end else if (cmd.div_step) begin
            rem_next = rem_ge ? DEN_W'(rem_dbl - {1'b0, den_reg}) : rem_dbl[DEN_W-1:0];
            quo_next = {quo_reg[SCORE_FRAC_BITS-2:0], rem_ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end else begin
            // divider holds between strings
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    // result payload; the score takes the length term when the divide ends
    always_ff @(posedge aclk) begin
        if (cmd.take && status.has_result) begin
            pos_out_reg     <= is_text ? text_pos_reg : '0;
            hit_out_reg     <= hit_now;
            done_out_reg    <= is_done;
            matched_out_reg <= is_done && ok_now;
            score_out_reg   <= status.need_div ? score_part : score_now;
        end else if (cmd.div_done) begin
            score_out_reg <= score_out_reg
                           + $signed({{(SCORE_W-SCORE_FRAC_BITS){1'b0}}, quo_next});
        end
    end

    assign text_position = pos_out_reg;
    assign hit           = hit_out_reg;
    assign done_res      = done_out_reg;
    assign matched       = matched_out_reg;
    assign score         = score_out_reg;

endmodule

// ----- sim/fuzzy_subsequence_scorer_test.sv -----
// self-checking testbench for the fuzzy subsequence scorer: stream driver, result monitor
// and a scoring predictor that keeps its own pattern store, string state and registers
// depends on fss_pkg and fuzzy_subsequence_scorer
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_test;
    import fss_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         SETTLE_CYC  = 40;
    localparam int         RANDOM_ITEMS = 1000;
    localparam char_t      CH_LOWER_A  = 16'h0061;
    localparam char_t      CH_UPPER_B  = 16'h0042;
    localparam char_t      CH_TOP      = 16'hFFFF;

    typedef struct packed {
        logic [1:0]       op;
        logic [SLOT_W-1:0] slot;
        char_t            ch;
        logic             last;
    } char_item_t;

    typedef struct packed {
        logic [POS_W-1:0]         text_position;
        logic                     hit;
        logic                     done_res;
        logic                     matched;
        logic [SCORE_W-1:0]       score;
    } outcome_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    fuzzy_subsequence_scorer dut (.*);

    always #2 aclk = ~aclk;

    // predictor state: registers, pattern store and per-string progress
    int unsigned reg_plen = 0;
    bit          reg_exact = 0;
    char_t       store_copy [PATTERN_MAX];
    int unsigned match_idx, cursor, last_hit_at, bonus_total, gap_total;
    bit          after_hit, seen_hit;
    char_t       prev_char;
    outcome_t    outcomes [$];

    // stimulus side
    char_item_t  pending_items [$];
    char_t       pat_img [PATTERN_MAX] = '{default: '0};
    int unsigned gen_plen;
    bit          gen_exact;
    int unsigned fed = 0;
    char_t       seps [5] = '{CH_SPACE, CH_SLASH, CH_BACKSLASH, CH_DASH, CH_UNDERSCORE};

    // handshake bookkeeping
    bit          s_took = 0, m_took = 0, s_busy = 0, s_calm = 0, m_calm = 0;
    int unsigned s_gap = 0, m_hold = 0, idle_cycles = 0;
    int unsigned mistakes = 0, results_seen = 0, strings_done = 0, strings_hit = 0;

    function automatic void restart_string();
        match_idx = 0;
        cursor = 0;
        after_hit = 0;
        last_hit_at = 0;
        seen_hit = 0;
        prev_char = '0;
        bonus_total = 0;
        gap_total = 0;
    endfunction

    function automatic char_t lower_of(char_t c);
        if (!reg_exact && c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic int unsigned active_len();
        return (reg_plen > PATTERN_MAX) ? PATTERN_MAX : reg_plen;
    endfunction

    // bonus minus half the gaps plus L/(L+1), or one for an empty pattern, clamped to the signed score range
    function automatic logic [SCORE_W-1:0] closing_score(int unsigned len);
        longint s;
        longint frac;
        if (active_len() == 0) begin
            s = longint'(1) << SCORE_FRAC_BITS;
        end else begin
            frac = (longint'(len) << SCORE_FRAC_BITS) / (longint'(len) + 1);
            s = (longint'(bonus_total) << SCORE_FRAC_BITS)
                - (longint'(gap_total) << (SCORE_FRAC_BITS - 1)) + frac;
        end
        if (s > (longint'(1) << (SCORE_W - 1)) - 1) s = (longint'(1) << (SCORE_W - 1)) - 1;
        if (s < -(longint'(1) << (SCORE_W - 1))) s = -(longint'(1) << (SCORE_W - 1));
        return s[SCORE_W-1:0];
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [SLOT_W-1:0] slot,
                                         char_t ch, logic last);
        outcome_t    r;
        int unsigned plen, pos, inc, g;
        bit          hit;
        plen = active_len();
        r = '0;
        case (op)
            OP_LOAD: begin
                store_copy[slot] = ch;
            end
            OP_EMPTY_END: begin
                r.done_res = 1'b1;
                if (plen == 0) begin
                    r.matched = 1'b1;
                    r.score = closing_score(0);
                end
                outcomes = {outcomes, r};
                restart_string();
            end
            OP_TEXT: begin
                pos = cursor;
                hit = 0;
                if (match_idx < plen && lower_of(store_copy[match_idx]) == lower_of(ch)) begin
                    hit = 1;
                    inc = 1;
                    if (after_hit) begin
                        inc += 2;
                    end else if (seen_hit && pos > last_hit_at) begin
                        g = gap_total + pos - last_hit_at - 1;
                        gap_total = (g > 4095) ? 4095 : g;
                    end
                    if (pos == 0 || prev_char inside {seps}) inc += 1;
                    bonus_total = (bonus_total + inc > 255) ? 255 : bonus_total + inc;
                    last_hit_at = pos;
                    seen_hit = 1;
                    match_idx++;
                end
                after_hit = hit;
                prev_char = ch;
                r.text_position = pos[POS_W-1:0];
                r.hit = hit;
                r.done_res = last;
                if (last) begin
                    if (match_idx >= plen) begin
                        r.matched = 1'b1;
                        r.score = closing_score(pos + 1);
                    end
                    restart_string();
                end else if (cursor < TEXT_MAX - 1) begin
                    cursor++;
                end
                outcomes = {outcomes, r};
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mistakes++;
        end
    endfunction

    // sample both channels and the register port, predict and compare
    always @(posedge aclk) begin
        outcome_t want, got;
        if (!aresetn) begin
            restart_string();
            reg_plen = 0;
            reg_exact = 0;
            s_took = 0;
            m_took = 0;
            idle_cycles = 0;
        end else begin
            s_took = s_tvalid && s_tready;
            m_took = m_tvalid && m_tready;
            if (cfg_we) begin
                if (cfg_index == REG_PATTERN_LENGTH) reg_plen = 32'(cfg_wdata);
                else reg_exact = cfg_wdata[0];
            end
            if (s_took)
                predict_item(s_tuser, s_tdata[SLOT_W-1:0], s_tdata[SLOT_W +: CHAR_W], s_tlast);
            if (m_took) begin
                got.text_position = m_tdata[POS_W-1:0];
                got.hit = m_tdata[POS_W];
                got.matched = m_tdata[POS_W+1];
                got.score = m_tdata[POS_W+2 +: SCORE_W];
                got.done_res = m_tlast;
                results_seen++;
                if (outcomes.size() == 0) begin
                    $error("result with nothing expected: position %0d done %0b",
                           got.text_position, got.done_res);
                    mistakes++;
                end else begin
                    want = outcomes.pop_front();
                    check_field("text_position", longint'(want.text_position),
                                longint'(got.text_position));
                    check_field("hit", longint'(want.hit), longint'(got.hit));
                    check_field("done_res", longint'(want.done_res), longint'(got.done_res));
                    check_field("matched", longint'(want.matched), longint'(got.matched));
                    check_field("score", longint'($signed(want.score)),
                                longint'($signed(got.score)));
                    if (want.done_res) strings_done++;
                    if (want.matched) strings_hit++;
                end
            end
            // watchdog on a stalled interface
            if (s_took || m_took || cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles with %0d results outstanding",
                         idle_cycles, outcomes.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // input driver, fed from the pending queue with random gaps
    always @(negedge aclk) begin
        char_item_t nxt;
        if (aresetn) begin
            if (s_took) begin
                s_busy = 0;
                if ($urandom_range(0, 39) == 0) s_calm = !s_calm;
                s_gap = s_calm ? 0 : $urandom_range(0, 10);
            end
            if (!s_busy && s_gap == 0 && pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                s_tuser <= nxt.op;
                s_tdata <= S_TDATA_W'({nxt.ch, nxt.slot});
                s_tlast <= nxt.last;
                s_tvalid <= 1'b1;
                s_busy = 1;
            end else if (!s_busy) begin
                s_tvalid <= 1'b0;
                if (s_gap != 0) s_gap--;
            end
        end
    end

    // result ready with random stalls after each item
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took) begin
                if ($urandom_range(0, 39) == 0) m_calm = !m_calm;
                m_hold = m_calm ? 0 : $urandom_range(0, 10);
            end
            if (m_hold != 0) begin
                m_tready <= 1'b0;
                m_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_item(logic [1:0] op, logic [SLOT_W-1:0] slot, char_t ch, logic last);
        char_item_t it;
        it.op = op;
        it.slot = slot;
        it.ch = ch;
        it.last = last;
        pending_items = {pending_items, it};
        if (op != OP_UNUSED) fed++;
    endtask

    task automatic load_slot(int unsigned idx, char_t c);
        pat_img[idx] = c;
        queue_item(OP_LOAD, idx[SLOT_W-1:0], c, 1'($urandom_range(0, 1)));
    endtask

    task automatic text_char(char_t c, logic last);
        queue_item(OP_TEXT, SLOT_W'($urandom_range(0, PATTERN_MAX - 1)), c, last);
    endtask

    // mostly letters so that texts hit, with separators and odd codes mixed in
    function automatic char_t filler();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CH_LOWER_A + char_t'($urandom_range(0, 7));
            4, 5:       return CH_UPPER_A + char_t'($urandom_range(0, 7));
            6:          return seps[$urandom_range(0, 4)];
            7:          return char_t'($urandom_range(0, 65535));
            8:          return $urandom_range(0, 1) ? CH_TOP : 16'h0000;
            default:    return pat_img[$urandom_range(0, PATTERN_MAX - 1)];
        endcase
    endfunction

    // a string built around the pattern, sometimes broken or pure noise
    task automatic queue_string(bit shaped);
        char_t       txt [$];
        char_t       c;
        int unsigned k, skip;
        if (shaped) begin
            skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gen_plen) : gen_plen + 1;
            for (k = 0; k < gen_plen; k++) begin
                repeat ($urandom_range(0, 3)) txt = {txt, filler()};
                if (k != skip) begin
                    c = pat_img[k];
                    if (!gen_exact && $urandom_range(0, 1) &&
                        ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                         (c >= CH_UPPER_A + CASE_OFFSET && c <= CH_UPPER_Z + CASE_OFFSET)))
                        c = c ^ CASE_OFFSET;
                    txt = {txt, c};
                end
            end
            repeat ($urandom_range(0, 2)) txt = {txt, filler()};
        end else begin
            repeat ($urandom_range(0, 12)) txt = {txt, filler()};
        end
        if (txt.size() == 0) begin
            queue_item(OP_EMPTY_END, SLOT_W'($urandom_range(0, 31)),
                       char_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end else begin
            for (k = 0; k < txt.size(); k++) begin
                if ($urandom_range(0, 29) == 0)
                    queue_item(OP_UNUSED, SLOT_W'($urandom_range(0, 31)),
                               char_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 49) == 0)
                    load_slot($urandom_range(0, PATTERN_MAX - 1), filler());
                text_char(txt[k], k == txt.size() - 1);
            end
        end
    endtask

    // wait for the queue to drain and every result to arrive, then let the interface idle
    task automatic settle();
        while (pending_items.size() != 0 || s_busy || outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_reg(logic idx, int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_PATTERN_LENGTH) gen_plen = val;
        else gen_exact = val[0];
    endtask

    initial begin
        int unsigned i, phase;
        gen_plen = 0;
        gen_exact = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty pattern out of reset: empty text, ignored opcode, one-character text
        queue_item(OP_EMPTY_END, 5'd0, 16'h0000, 1'b0);
        queue_item(OP_UNUSED, 5'd31, CH_TOP, 1'b1);
        text_char(CH_TOP, 1'b1);
        // write every slot so no unloaded entry is ever compared
        for (i = 0; i < PATTERN_MAX; i++) load_slot(i, filler());
        load_slot(0, CH_LOWER_A);
        load_slot(1, CH_UPPER_B);
        load_slot(2, CH_TOP);
        settle();

        // folded compare, word start after a slash, a gap, consecutive bonus, complete pattern
        set_reg(REG_PATTERN_LENGTH, 3);
        set_reg(REG_CASE_SENSITIVE, 0);
        text_char(CH_LOWER_A + 16'd23, 1'b0);
        text_char(CH_UPPER_A, 1'b0);
        text_char(CH_SLASH, 1'b0);
        text_char(CH_UPPER_B + CASE_OFFSET, 1'b0);
        text_char(CH_TOP, 1'b0);
        text_char(CH_LOWER_A, 1'b1);
        queue_item(OP_EMPTY_END, 5'd31, CH_TOP, 1'b1);
        text_char(CH_UPPER_A, 1'b0);
        text_char(16'h0000, 1'b1);
        text_char(CH_LOWER_A, 1'b0);
        text_char(CH_UPPER_B + CASE_OFFSET, 1'b0);
        text_char(CH_TOP, 1'b1);
        settle();

        // exact compare: the lower-case letter no longer matches
        set_reg(REG_CASE_SENSITIVE, 1);
        text_char(CH_LOWER_A, 1'b0);
        text_char(CH_UPPER_B + CASE_OFFSET, 1'b0);
        text_char(CH_TOP, 1'b1);

        // random phases, the register extremes first
        fed = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS) begin
            settle();
            case (phase)
                0: begin
                    set_reg(REG_PATTERN_LENGTH, PATTERN_MAX);
                    set_reg(REG_CASE_SENSITIVE, 1);
                end
                1: begin
                    set_reg(REG_PATTERN_LENGTH, 0);
                    set_reg(REG_CASE_SENSITIVE, 0);
                end
                default: begin
                    case ($urandom_range(0, 7))
                        0:       set_reg(REG_PATTERN_LENGTH, 0);
                        1:       set_reg(REG_PATTERN_LENGTH, PATTERN_MAX);
                        2, 3:    set_reg(REG_PATTERN_LENGTH, $urandom_range(1, 3));
                        default: set_reg(REG_PATTERN_LENGTH, $urandom_range(1, 8));
                    endcase
                    set_reg(REG_CASE_SENSITIVE, $urandom_range(0, 1));
                end
            endcase
            for (i = 0; i < gen_plen; i++) load_slot(i, filler());
            repeat ($urandom_range(3, 8)) queue_string($urandom_range(0, 3) != 0);
            phase++;
        end
        settle();

        $display("checked %0d results over %0d strings, %0d matched, in %0d register phases",
                 results_seen, strings_done, strings_hit, phase + 3);
        if (mistakes == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/fss_pkg.sv
src/fss_ctrl.sv
src/fss_datapath.sv
src/fuzzy_subsequence_scorer.sv
sim/fuzzy_subsequence_scorer_test.sv
